// ===== src/ring_buffer_packet_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ring buffer packet deframer
// Checks are clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef RING_BUFFER_PACKET_DEFRAMER_ASSERT_SVH
`define RING_BUFFER_PACKET_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define RBPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbpd check failed");

// next-cycle implication
`define RBPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbpd check failed");

`endif

// ===== src/rbpd_pkg.sv =====
// ----------------------------------------------------------------------------
// rbpd_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
package rbpd_pkg;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POLL = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_FULL   = 3'd1,
    ST_NONE   = 3'd2,
    ST_BYTE   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_HEAD_LEN    = 3'd0,
    CFG_TAIL_LEN    = 3'd1,
    CFG_HEAD_SEQ    = 3'd2,
    CFG_TAIL_SEQ    = 3'd3,
    CFG_MAX_PAYLOAD = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_RESULT,
    FSM_SCAN,
    FSM_PAY_RD,
    FSM_PAY_WR
  } fsm_e;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] payload_byte;
    logic       last;
    logic [8:0] fill_level;
  } out_t;

  localparam logic [2:0]  HeadLenRst    = 3'd2;
  localparam logic [2:0]  TailLenRst    = 3'd2;
  localparam logic [31:0] HeadSeqRst    = 32'h0000_0000;
  localparam logic [31:0] TailSeqRst    = 32'h0000_0A0D;
  localparam logic [5:0]  MaxPayloadRst = 6'd63;

  // byte idx of a sequence word; bytes past the fourth read as zero
  function automatic logic [7:0] seq_byte(input logic [31:0] seq, input logic [3:0] idx);
    logic [31:0] sh;
    sh = seq >> {idx, 3'b000};
    return (idx < 4'd4) ? sh[7:0] : 8'h00;
  endfunction

endpackage

// ===== src/rbpd_ram.sv =====
// ----------------------------------------------------------------------------
// rbpd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rbpd_seq_match.sv =====
// ----------------------------------------------------------------------------
// rbpd_seq_match
// Compares the newest len bytes of the byte window against a sequence word.
// ----------------------------------------------------------------------------
module rbpd_seq_match #(
  parameter int MAX_SEQ_LEN = 4,
  parameter int LW          = 3
) (
  input  logic [MAX_SEQ_LEN-1:0][7:0] win_i,
  input  logic [31:0]                 seq_i,
  input  logic [LW-1:0]               len_i,
  output logic                        match_o
);

  import rbpd_pkg::*;

  logic [3:0] len4;

  assign len4 = 4'(len_i);

  // win_i[0] is the newest byte; it pairs with sequence byte len-1
  always_comb begin
    match_o = 1'b1;
    for (int m = 0; m < MAX_SEQ_LEN; m++) begin
      if (4'(m) < len4) begin
        if (win_i[m] != seq_byte(seq_i, len4 - 4'(m) - 4'd1)) begin
          match_o = 1'b0;
        end
      end
    end
  end

endmodule

// ===== src/ring_buffer_packet_deframer.sv =====
// ----------------------------------------------------------------------------
// ring_buffer_packet_deframer
// Received-byte ring with head/tail delimited packet extraction.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  (in_valid_i/in_ready_o/in_data_i): push beats store rx_byte,
//   poll beats extract at most one packet. out channel gives result beats,
//   last marks the final beat of an item. cfg channel writes the registers
//   by index, always ready; write only while idle.
// Flow:
//   push: store the beat if there is room, then present its result; no new
//   beat is taken before that. poll: one ring byte read per cycle from the
//   single RAM read port while scanning; each payload byte is read, then
//   presented when the out slot is free. A poll rejected up front skips the scan.
// Stalls: the result sits in an output register; the next item is taken
//   while it waits, and work halts only when a new result needs that slot.
// Reset: pointers cleared, ring empty, registers to defaults; the ring RAM
//   itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module ring_buffer_packet_deframer #(
  parameter int RING_DEPTH  = 512,
  parameter int MAX_SEQ_LEN = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rbpd_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbpd_pkg::out_t  out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i
);

  import rbpd_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int XW = PW + 5;
  localparam int LW = $clog2(MAX_SEQ_LEN + 1);
  localparam logic [PW:0] DepthX = (PW + 1)'(RING_DEPTH);

  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [PW-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= DepthX) begin
      s = s - DepthX;
    end
    return s[PW-1:0];
  endfunction

  // ---------------- registers ----------------
  fsm_e            state_q, state_d;
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [2:0]      head_len_q, tail_len_q;
  logic [31:0]     head_seq_q, tail_seq_q;
  logic [5:0]      max_pay_q;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;
  logic            rvld_q, rvld_d;
  logic            hf_q, hf_d;
  status_e         res_st_q, res_st_d;
  logic [PW-1:0]   cnt_q, cnt_d, iss_q, iss_d, seen_q, seen_d;
  logic [PW-1:0]   hp_q, hp_d, tcnt_q, tcnt_d, pbase_q, pbase_d;
  logic [5:0]      k_q, k_d, plen_q, plen_d;
  logic [MAX_SEQ_LEN-1:0][7:0] win_q, win_d;

  // ---------------- RAM ----------------
  logic            ram_we, ram_re;
  logic [PW-1:0]   ram_raddr;
  logic [7:0]      ram_rdata;

  rbpd_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (in_data_i.rx_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- derived values ----------------
  logic [PW:0]     fill_w;
  logic [PW-1:0]   fill;
  logic [PW+8:0]   fill_ext;
  logic [8:0]      fill_lvl;
  logic [LW-1:0]   hl, tl;
  logic [XW-1:0]   hl_x, tl_x, sum_x;
  logic            in_acc, slot_free;

  always_comb begin
    if (wp_q >= rp_q) begin
      fill_w = {1'b0, wp_q} - {1'b0, rp_q};
    end else begin
      fill_w = DepthX - {1'b0, rp_q} + {1'b0, wp_q};
    end
  end
  assign fill     = fill_w[PW-1:0];
  assign fill_ext = (PW + 9)'(fill);
  assign fill_lvl = fill_ext[8:0];

  always_comb begin
    if (head_len_q == 3'd0) begin
      hl = LW'(1);
    end else if ({1'b0, head_len_q} > 4'(MAX_SEQ_LEN)) begin
      hl = LW'(MAX_SEQ_LEN);
    end else begin
      hl = LW'(head_len_q);
    end
    if (tail_len_q == 3'd0) begin
      tl = LW'(1);
    end else if ({1'b0, tail_len_q} > 4'(MAX_SEQ_LEN)) begin
      tl = LW'(MAX_SEQ_LEN);
    end else begin
      tl = LW'(tail_len_q);
    end
  end
  assign hl_x  = XW'(hl);
  assign tl_x  = XW'(tl);
  assign sum_x = hl_x + tl_x;

  assign in_ready_o  = (state_q == FSM_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign cfg_ready_o = 1'b1;

  // ---------------- scan evaluation ----------------
  logic [MAX_SEQ_LEN-1:0][7:0] win_now;
  logic            head_match, tail_match;
  logic [PW-1:0]   seen_n, tcnt_n, hp_new;
  logic [XW-1:0]   plen_x, keep_x;
  logic            head_hit, head_short, tail_hit, too_long, at_end;
  logic            scan_done, scan_pay;
  status_e         scan_st;
  logic [PW-1:0]   scan_rp;

  always_comb begin
    win_now[0] = ram_rdata;
    for (int m = 1; m < MAX_SEQ_LEN; m++) begin
      win_now[m] = win_q[m-1];
    end
  end

  rbpd_seq_match #(.MAX_SEQ_LEN(MAX_SEQ_LEN), .LW(LW)) u_head_match (
    .win_i   (win_now),
    .seq_i   (head_seq_q),
    .len_i   (hl),
    .match_o (head_match)
  );

  rbpd_seq_match #(.MAX_SEQ_LEN(MAX_SEQ_LEN), .LW(LW)) u_tail_match (
    .win_i   (win_now),
    .seq_i   (tail_seq_q),
    .len_i   (tl),
    .match_o (tail_match)
  );

  always_comb begin
    seen_n     = seen_q + PW'(1);
    tcnt_n     = tcnt_q + PW'(1);
    hp_new     = PW'(XW'(seen_n) - hl_x);
    plen_x     = XW'(tcnt_n) - tl_x;
    keep_x     = (hl > LW'(1)) ? hl_x - XW'(1) : XW'(1);
    head_hit   = rvld_q && !hf_q && (XW'(seen_n) >= hl_x) && head_match;
    head_short = (XW'(cnt_q) - XW'(hp_new)) < sum_x;
    tail_hit   = rvld_q && hf_q && (XW'(tcnt_n) >= tl_x) && tail_match;
    too_long   = plen_x > XW'(max_pay_q);
    at_end     = rvld_q && (seen_n == cnt_q);

    scan_done = 1'b0;
    scan_pay  = 1'b0;
    scan_st   = ST_NONE;
    scan_rp   = rp_q;
    if (head_hit) begin
      if (head_short) begin
        scan_done = 1'b1;
        scan_rp   = wrap_add(rp_q, hp_new);
      end
    end else if (tail_hit) begin
      scan_done = 1'b1;
      if (too_long) begin
        scan_rp = wrap_add(rp_q, hp_q + PW'(1));
      end else begin
        scan_rp = wrap_add(rp_q, PW'(XW'(hp_q) + hl_x + XW'(tcnt_n)));
        if (plen_x == '0) begin
          scan_st = ST_EMPTY;
        end else begin
          scan_pay = 1'b1;
        end
      end
    end else if (at_end) begin
      scan_done = 1'b1;
      if (hf_q) begin
        // head seen, tail missing: only the noise goes
        scan_rp = wrap_add(rp_q, hp_q);
      end else begin
        scan_rp = wrap_add(rp_q, PW'(XW'(cnt_q) - keep_x));
      end
    end
  end

  // ---------------- next state ----------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          if (in_data_i.opcode == OP_POLL && max_pay_q != 6'd0 && XW'(fill) >= sum_x) begin
            state_d = FSM_SCAN;
          end else begin
            state_d = FSM_RESULT;
          end
        end
      end
      FSM_RESULT: begin
        if (slot_free) begin
          state_d = FSM_IDLE;
        end
      end
      FSM_SCAN: begin
        if (scan_done) begin
          state_d = scan_pay ? FSM_PAY_RD : FSM_RESULT;
        end
      end
      FSM_PAY_RD: begin
        state_d = FSM_PAY_WR;
      end
      FSM_PAY_WR: begin
        if (slot_free) begin
          state_d = (k_q + 6'd1 == plen_q) ? FSM_IDLE : FSM_PAY_RD;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  // ---------------- datapath and outputs ----------------
  always_comb begin
    wp_d        = wp_q;
    rp_d        = rp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rvld_d      = 1'b0;
    hf_d        = hf_q;
    res_st_d    = res_st_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    seen_d      = seen_q;
    hp_d        = hp_q;
    tcnt_d      = tcnt_q;
    pbase_d     = pbase_q;
    k_d         = k_q;
    plen_d      = plen_q;
    win_d       = win_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = wrap_add(rp_q, iss_q);

    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          cnt_d  = fill;
          iss_d  = '0;
          seen_d = '0;
          hf_d   = 1'b0;
          tcnt_d = '0;
          if (in_data_i.opcode == OP_PUSH) begin
            if (fill_w >= DepthX - (PW + 1)'(1)) begin
              res_st_d = ST_FULL;
            end else begin
              ram_we   = 1'b1;
              wp_d     = wrap_add(wp_q, PW'(1));
              res_st_d = ST_STORED;
            end
          end else begin
            res_st_d = ST_NONE;
          end
        end
      end
      FSM_RESULT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = res_st_q;
          out_d.payload_byte = 8'h00;
          out_d.last         = 1'b1;
          out_d.fill_level   = fill_lvl;
        end
      end
      FSM_SCAN: begin
        if (iss_q != cnt_q && !scan_done) begin
          ram_re = 1'b1;
          rvld_d = 1'b1;
          iss_d  = iss_q + PW'(1);
        end
        if (rvld_q) begin
          win_d  = win_now;
          seen_d = seen_n;
          if (hf_q) begin
            tcnt_d = tcnt_n;
          end
        end
        if (head_hit && !head_short) begin
          hf_d   = 1'b1;
          hp_d   = hp_new;
          tcnt_d = '0;
        end
        if (scan_done) begin
          rp_d     = scan_rp;
          res_st_d = scan_st;
          pbase_d  = wrap_add(rp_q, PW'(XW'(hp_q) + hl_x));
          plen_d   = plen_x[5:0];
          k_d      = '0;
        end
      end
      FSM_PAY_RD: begin
        ram_re    = 1'b1;
        ram_raddr = wrap_add(pbase_q, PW'(k_q));
      end
      FSM_PAY_WR: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = ST_BYTE;
          out_d.payload_byte = ram_rdata;
          out_d.last         = (k_q + 6'd1 == plen_q);
          out_d.fill_level   = fill_lvl;
          k_d                = k_q + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      out_valid_q <= 1'b0;
      rvld_q      <= 1'b0;
      hf_q        <= 1'b0;
      head_len_q  <= HeadLenRst;
      tail_len_q  <= TailLenRst;
      head_seq_q  <= HeadSeqRst;
      tail_seq_q  <= TailSeqRst;
      max_pay_q   <= MaxPayloadRst;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      out_valid_q <= out_valid_d;
      rvld_q      <= rvld_d;
      hf_q        <= hf_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_HEAD_LEN:    head_len_q <= cfg_data_i[2:0];
          CFG_TAIL_LEN:    tail_len_q <= cfg_data_i[2:0];
          CFG_HEAD_SEQ:    head_seq_q <= cfg_data_i;
          CFG_TAIL_SEQ:    tail_seq_q <= cfg_data_i;
          CFG_MAX_PAYLOAD: max_pay_q  <= cfg_data_i[5:0];
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------- payload registers ----------------
  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    res_st_q <= res_st_d;
    cnt_q    <= cnt_d;
    iss_q    <= iss_d;
    seen_q   <= seen_d;
    hp_q     <= hp_d;
    tcnt_q   <= tcnt_d;
    pbase_q  <= pbase_d;
    k_q      <= k_d;
    plen_q   <= plen_d;
    win_q    <= win_d;
  end

  // ---------------- assertions ----------------
`include "ring_buffer_packet_deframer_assert.svh"

  `RBPD_ASSERT_IMP(a_no_rw_collision, ram_we, !ram_re)
  `RBPD_ASSERT_NXT(a_wp_only_on_push, !(in_acc && in_data_i.opcode == OP_PUSH), wp_q == $past(wp_q))
  `RBPD_ASSERT_NXT(a_last_to_idle, (out_valid_d && !(out_valid_q && !out_ready_i) && out_d.last), state_q == FSM_IDLE)
  `RBPD_ASSERT_IMP(a_fill_bound, 1'b1, fill_w <= DepthX - (PW + 1)'(1))

endmodule
